// File: rtl/core/antialiased_line_rasterizer_macros.svh
// ---------------------------------------------------------------------------
// Antialiased line rasterizer assertion macros
// Concurrent assertion shorthands, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_RASTERIZER_MACROS_SVH
`define ANTIALIASED_LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define ALR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ALR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/alr_pkg.sv
// ---------------------------------------------------------------------------
// Antialiased line rasterizer package
// Request and pixel types, request codes and shared constants.
// ---------------------------------------------------------------------------
package alr_pkg;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 24;
  localparam int COV_W   = 9;

  // request codes
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [COV_W-1:0] COV_FULL = 9'd256;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        line_color;
  } alr_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic [COV_W-1:0]          coverage;
    logic                      line_done;
  } alr_pix_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } alr_div_stat_t;

endpackage

// File: rtl/core/alr_div.sv
// ---------------------------------------------------------------------------
// Antialiased line rasterizer slope divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module alr_div import alr_pkg::*; #(
  parameter int NUM_BITS = 32,
  parameter int DEN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output alr_div_stat_t       stat_o,
  output logic [NUM_BITS-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [NUM_BITS-1:0] quo_q, quo_d;
  logic [DEN_BITS-1:0] den_q, den_d;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[NUM_BITS-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_BITS);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
      quo_d = {quo_q[NUM_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quo_q;

endmodule

// File: rtl/core/antialiased_line_rasterizer.sv
// ---------------------------------------------------------------------------
// Antialiased line rasterizer
// Wu-style line stepper with coverage weights and a serial slope divider.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  : valid/ready requests. A start request carries both endpoints
//                 and the color; an advance request steps one major position.
//   out channel : valid/ready pixels with position, color, coverage and a
//                 line_done flag on the far endpoint.
//   Start: setup (endpoint ordering, then the differences), then the
//   restoring divider for the slope (one quotient bit a cycle), then the
//   start pixel is loaded into the output register. A single-point line
//   skips the divider.
//   Advance: two pixels, one output register load each; the far endpoint
//   gives one pixel.
//   An advance with no active line is taken and dropped.
//   The block takes no request until all pixels of the previous one are
//   loaded into the output register; a stalled receiver holds the block.
//   Reset clears the active line and empties the output register.
// ---------------------------------------------------------------------------
`include "antialiased_line_rasterizer_macros.svh"

module antialiased_line_rasterizer import alr_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  alr_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output alr_pix_t out_pix_o
);

  localparam int C = COORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int A = COORD_BITS + FRAC_BITS;
  localparam int S = FRAC_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SLOPE,
    S_DIV,
    S_EMIT_START,
    S_EMIT_LO,
    S_EMIT_HI,
    S_EMIT_END
  } state_e;

  state_e state_q, state_d;
  logic   line_active_q, line_active_d;
  logic   out_valid_q, out_valid_d;

  logic                y_major_q, y_major_d;
  logic signed [C-1:0] major_pos_q, major_pos_d;
  logic signed [C-1:0] major_end_q, major_end_d;
  logic signed [C-1:0] end_minor_q, end_minor_d;
  logic signed [A-1:0] minor_acc_q, minor_acc_d;
  logic signed [S-1:0] slope_q, slope_d;
  logic                neg_q, neg_d;
  logic [COLOR_W-1:0]  color_q, color_d;
  logic signed [C-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [C-1:0] sx_d, sy_d, ex_d, ey_d;
  alr_pix_t            out_q, out_d;

  // setup datapath
  logic signed [C:0]   dx, dy, adx, ady, dmaj, dmin, dmin_mag;
  logic                ymaj, swap, dneg;
  logic signed [C-1:0] maj0r, min0r, maj1r, min1r;
  logic signed [C-1:0] maj0, min0, maj1, min1;

  // advance datapath
  logic signed [C:0]   pos_next, end_ext;

  // emit datapath
  logic signed [C-1:0] em_maj, em_min, fl;
  logic [7:0]          frac8;
  logic [COV_W-1:0]    em_cov;
  logic                em_done, em_active, slot_free;
  alr_pix_t            em_pix;

  // divider
  logic                div_start;
  logic [A-1:0]        div_num;
  logic [A-1:0]        div_quot;
  alr_div_stat_t       div_stat;

  assign dx  = {ex_q[C-1], ex_q} - {sx_q[C-1], sx_q};
  assign dy  = {ey_q[C-1], ey_q} - {sy_q[C-1], sy_q};
  assign adx = dx[C] ? -dx : dx;
  assign ady = dy[C] ? -dy : dy;
  assign ymaj = !(adx > ady);

  assign maj0r = ymaj ? sy_q : sx_q;
  assign min0r = ymaj ? sx_q : sy_q;
  assign maj1r = ymaj ? ey_q : ex_q;
  assign min1r = ymaj ? ex_q : ey_q;
  assign swap  = (maj1r < maj0r);
  assign maj0  = swap ? maj1r : maj0r;
  assign min0  = swap ? min1r : min0r;
  assign maj1  = swap ? maj0r : maj1r;
  assign min1  = swap ? min0r : min1r;

  // differences from the ordered endpoints held in the line registers
  assign dmaj     = {major_end_q[C-1], major_end_q} - {major_pos_q[C-1], major_pos_q};
  assign dmin     = {end_minor_q[C-1], end_minor_q} - {fl[C-1], fl};
  assign dneg     = dmin[C];
  assign dmin_mag = dneg ? -dmin : dmin;
  assign div_num  = {dmin_mag[C-1:0], {F{1'b0}}};

  assign pos_next = {major_pos_q[C-1], major_pos_q} + (C+1)'(1);
  assign end_ext  = {major_end_q[C-1], major_end_q};

  alr_div #(
    .NUM_BITS(A),
    .DEN_BITS(C)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (dmaj[C-1:0]),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  assign fl        = minor_acc_q[A-1:F];
  assign frac8     = minor_acc_q[F-1 -: 8];
  assign slot_free = !out_valid_q || out_ready_i;

  // pixel for the current emit state
  always_comb begin
    em_maj    = major_pos_q;
    em_min    = fl;
    em_cov    = COV_FULL;
    em_done   = 1'b0;
    em_active = 1'b0;
    unique case (state_q)
      S_EMIT_START: begin
        em_done   = !line_active_q;
        em_active = 1'b1;
      end
      S_EMIT_LO: begin
        em_cov    = COV_FULL - {1'b0, frac8};
        em_active = 1'b1;
      end
      S_EMIT_HI: begin
        em_min    = fl + C'(1);
        em_cov    = {1'b0, frac8};
        em_active = 1'b1;
      end
      S_EMIT_END: begin
        em_maj    = major_end_q;
        em_min    = end_minor_q;
        em_done   = 1'b1;
        em_active = 1'b1;
      end
      default: begin
        em_active = 1'b0;
      end
    endcase
    em_pix.pixel_x     = COORD_W'(y_major_q ? em_min : em_maj);
    em_pix.pixel_y     = COORD_W'(y_major_q ? em_maj : em_min);
    em_pix.pixel_color = color_q;
    em_pix.coverage    = em_cov;
    em_pix.line_done   = em_done;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    line_active_d = line_active_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    y_major_d     = y_major_q;
    major_pos_d   = major_pos_q;
    major_end_d   = major_end_q;
    end_minor_d   = end_minor_q;
    minor_acc_d   = minor_acc_q;
    slope_d       = slope_q;
    neg_d         = neg_q;
    color_d       = color_q;
    sx_d          = sx_q;
    sy_d          = sy_q;
    ex_d          = ex_q;
    ey_d          = ey_q;
    div_start     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.req_type == REQ_START) begin
            sx_d    = in_req_i.start_x[C-1:0];
            sy_d    = in_req_i.start_y[C-1:0];
            ex_d    = in_req_i.end_x[C-1:0];
            ey_d    = in_req_i.end_y[C-1:0];
            color_d = in_req_i.line_color;
            state_d = S_SETUP;
          end else if (line_active_q) begin
            major_pos_d = pos_next[C-1:0];
            if (pos_next >= end_ext) begin
              line_active_d = 1'b0;
              state_d       = S_EMIT_END;
            end else begin
              minor_acc_d = minor_acc_q + A'(slope_q);
              state_d     = S_EMIT_LO;
            end
          end
        end
      end
      S_SETUP: begin
        y_major_d   = ymaj;
        major_pos_d = maj0;
        major_end_d = maj1;
        end_minor_d = min1;
        minor_acc_d = {min0, {F{1'b0}}};
        state_d     = S_SLOPE;
      end
      S_SLOPE: begin
        neg_d = dneg;
        if (dmaj == '0) begin
          line_active_d = 1'b0;
          slope_d       = '0;
          state_d       = S_EMIT_START;
        end else begin
          line_active_d = 1'b1;
          div_start     = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          slope_d = neg_q ? -S'(div_quot) : S'(div_quot);
          state_d = S_EMIT_START;
        end
      end
      S_EMIT_START, S_EMIT_LO, S_EMIT_HI, S_EMIT_END: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = em_pix;
          state_d     = (state_q == S_EMIT_LO) ? S_EMIT_HI : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    y_major_q   <= y_major_d;
    major_pos_q <= major_pos_d;
    major_end_q <= major_end_d;
    end_minor_q <= end_minor_d;
    minor_acc_q <= minor_acc_d;
    slope_q     <= slope_d;
    neg_q       <= neg_d;
    color_q     <= color_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    ex_q        <= ex_d;
    ey_q        <= ey_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_q;

  `ALR_ASSERT_IMPL(a_div_only_in_div, clk_i, rst_ni, div_stat.busy, state_q == S_DIV)
  `ALR_ASSERT_IMPL(a_done_full_cov, clk_i, rst_ni, out_valid_o && out_pix_o.line_done, out_pix_o.coverage == COV_FULL)
  `ALR_ASSERT_IMPL(a_pos_below_end, clk_i, rst_ni, line_active_q && (state_q == S_IDLE), major_pos_q < major_end_q)
  `ALR_ASSERT_NEXT(a_adv_emits, clk_i, rst_ni, in_valid_i && in_ready_o && (in_req_i.req_type == REQ_ADVANCE) && line_active_q, (state_q == S_EMIT_LO) || (state_q == S_EMIT_END))

endmodule
